### src/rmsc_pkg.sv
`timescale 1ns / 1ps

package rmsc_pkg;

    // Defaults for the top-level parameters.
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int TABLE_DEPTH_DEF  = 256;

    // Configuration port index width and register indexes.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD_DB = 4'd0,
        REG_SLOPE        = 4'd1,
        REG_KNEE_WIDTH   = 4'd2,
        REG_KNEE_CURVE   = 4'd3,
        REG_MAKEUP_GAIN  = 4'd4,
        REG_RMS_COEF     = 4'd5,
        REG_ATTACK_COEF  = 4'd6,
        REG_RELEASE_STEP = 4'd7
    } reg_idx_t;

    // Reset values of the configuration registers.
    localparam logic signed [15:0] THRESHOLD_RST = -16'sd5120;
    localparam logic [15:0] SLOPE_RST        = 16'd43690;
    localparam logic [12:0] KNEE_WIDTH_RST   = 13'd256;
    localparam logic [23:0] KNEE_CURVE_RST   = 24'd43690;
    localparam logic [15:0] MAKEUP_GAIN_RST  = 16'd5461;
    localparam logic [24:0] RMS_COEF_RST     = 25'd16777;
    localparam logic [24:0] ATTACK_COEF_RST  = 25'd17476;
    localparam logic [15:0] RELEASE_STEP_RST = 16'd164;

    // Fixed-point constants.
    localparam logic [24:0] FULL_Q24   = 25'd16777216;
    localparam logic [6:0]  LOG_EPS    = 7'd70;
    localparam logic [17:0] DB_PER_OCT = 18'd197284;
    localparam logic [21:0] OCT_PER_DB = 22'd2786688;
    localparam logic [14:0] METER_MAX  = 15'd24576;

    // Configuration register set as seen by the engine.
    typedef struct packed {
        logic signed [15:0] threshold_db;
        logic [15:0]        slope;
        logic [12:0]        knee_width;
        logic [23:0]        knee_curve;
        logic [15:0]        makeup_gain;
        logic [24:0]        rms_coef;
        logic [24:0]        attack_coef;
        logic [15:0]        release_step;
    } cfg_t;

endpackage

### src/rmsc_mul.sv
`timescale 1ns / 1ps

// Shared signed multiplier used by the multiply steps of the sequencer.
module rmsc_mul (
    input  logic signed [33:0] op_a,
    input  logic signed [33:0] op_b,
    output logic signed [67:0] prod
);

    assign prod = op_a * op_b;

endmodule

### src/rmsc_tables.sv
`timescale 1ns / 1ps

// Constant log2 and exp2 tables, built at elaboration.
module rmsc_tables #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic [$clog2(TABLE_DEPTH)-1:0] log_idx,
    input  logic [$clog2(TABLE_DEPTH)-1:0] exp_idx,
    output logic [15:0]                    log_val,
    output logic [30:0]                    exp_val
);

    typedef logic [15:0] log_arr_t [TABLE_DEPTH];
    typedef logic [30:0] exp_arr_t [TABLE_DEPTH];

    // Floor integer square root, one result bit per pass.
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        int          n;
        rem  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (n = 0; n < 32; n++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Entry i is log2(1 + i/D) in Q0.16, by repeated squaring.
    function automatic log_arr_t build_log();
        log_arr_t    t;
        logic [63:0] x;
        logic [15:0] r;
        int          i;
        int          k;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            x = ((64'(TABLE_DEPTH) + 64'(i)) << 30) / 64'(TABLE_DEPTH);
            r = '0;
            for (k = 0; k < 16; k++) begin
                x = (x * x) >> 30;
                r = {r[14:0], 1'b0};
                if (x >= (64'd1 << 31)) begin
                    r[0] = 1'b1;
                    x    = x >> 1;
                end
            end
            t[i] = r;
        end
        return t;
    endfunction

    // Entry i is 2^-(i/D) in Q1.30, a product of square roots of one half.
    function automatic exp_arr_t build_exp();
        exp_arr_t    t;
        logic [63:0] q;
        logic [63:0] y;
        logic [63:0] r;
        int          i;
        int          j;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            q = (64'(i) << 16) / 64'(TABLE_DEPTH);
            y = 64'd1 << 30;
            r = 64'd1 << 29;
            for (j = 1; j <= 16; j++) begin
                r = isqrt(r << 30);
                if (q[16-j]) begin
                    y = (y * r) >> 30;
                end
            end
            t[i] = 31'(y);
        end
        return t;
    endfunction

    localparam log_arr_t LOG_TAB = build_log();
    localparam exp_arr_t EXP_TAB = build_exp();

    assign log_val = LOG_TAB[log_idx];
    assign exp_val = EXP_TAB[exp_idx];

endmodule

### src/rmsc_engine.sv
`timescale 1ns / 1ps

// Sequencer and datapath: one sample pair walks through the shared multiplier.
module rmsc_engine #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int TABLE_DEPTH  = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rmsc_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] in_left,
    input  logic signed [SAMPLE_WIDTH-1:0] in_right,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [SAMPLE_WIDTH-1:0]        out_left,
    output logic [SAMPLE_WIDTH-1:0]        out_right,
    output logic [14:0]                    out_meter
);

    import rmsc_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SH_L  = (SW < 24) ? (24 - SW) : 0;
    localparam int SH_R  = (SW >= 24) ? (SW - 24) : 0;
    localparam logic [35:0] HALF36 = 36'd1 << (SW - 1);
    localparam logic [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [28:0] {
        ST_IDLE = 29'd1 << 0,
        ST_SQL  = 29'd1 << 1,
        ST_SQR  = 29'd1 << 2,
        ST_DIFF = 29'd1 << 3,
        ST_M0   = 29'd1 << 4,
        ST_M1   = 29'd1 << 5,
        ST_M2   = 29'd1 << 6,
        ST_M3   = 29'd1 << 7,
        ST_NORM = 29'd1 << 8,
        ST_IDX0 = 29'd1 << 9,
        ST_IDX1 = 29'd1 << 10,
        ST_LOG  = 29'd1 << 11,
        ST_LVL  = 29'd1 << 12,
        ST_TGT  = 29'd1 << 13,
        ST_KNEE = 29'd1 << 14,
        ST_ENV  = 29'd1 << 15,
        ST_EXP  = 29'd1 << 16,
        ST_EIDX = 29'd1 << 17,
        ST_GAIN = 29'd1 << 18,
        ST_OL0  = 29'd1 << 19,
        ST_OL1  = 29'd1 << 20,
        ST_OR0  = 29'd1 << 21,
        ST_OR1  = 29'd1 << 22,
        ST_DONE = 29'd1 << 23
    } state_t;

    // Control state.
    state_t      state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic        ovalid_reg, ovalid_next;
    logic [47:0] msq_reg, msq_next;
    logic [31:0] red_reg, red_next;

    // Payload registers.
    logic signed [SW-1:0] sl_reg, sl_next;
    logic signed [SW-1:0] sr_reg, sr_next;
    logic [63:0]          acc_reg, acc_next;
    logic [47:0]          a_reg, a_next;
    logic                 dir_reg, dir_next;
    logic [48:0]          nrm_reg, nrm_next;
    logic [5:0]           lz_reg, lz_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic signed [24:0]   lg_reg, lg_next;
    logic signed [26:0]   over_reg, over_next;
    logic [31:0]          tgt_reg, tgt_next;
    logic [25:0]          kt_reg, kt_next;
    logic [29:0]          e_reg, e_next;
    logic [IDX_W-1:0]     eidx_reg, eidx_next;
    logic [24:0]          g24_reg, g24_next;
    logic [31:0]          t_reg, t_next;
    logic [SW-1:0]        resl_reg, resl_next;
    logic [SW-1:0]        resr_reg, resr_next;
    logic [SW-1:0]        outl_reg, outl_next;
    logic [SW-1:0]        outr_reg, outr_next;
    logic [14:0]          meter_reg, meter_next;

    // Shared unit and tables.
    logic signed [33:0] op_a, op_b;
    logic signed [67:0] prod;
    logic [15:0]        log_val;
    logic [30:0]        exp_val;

    // Helpers.
    logic [SW-1:0]      magl, magr;
    logic [23:0]        nl, nr;
    logic [24:0]        rc, ac;
    logic [11:0]        rc_lo;
    logic [12:0]        rc_hi;
    logic signed [27:0] two_over, w_full, half_w, x_knee;
    logic               zone_low, zone_high;
    logic [63:0]        sum64;
    logic [5:0]         amt;
    logic [15:0]        shamt;
    logic [35:0]        mag36;
    logic               neg_s;
    logic [SW-1:0]      sat_val;

    rmsc_mul u_mul (
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    rmsc_tables #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_tables (
        .log_idx (idx_reg),
        .exp_idx (eidx_reg),
        .log_val (log_val),
        .exp_val (exp_val)
    );

    // Sample magnitudes, and detection samples rescaled to 24 bits.
    always_comb
    begin
        magl = sl_reg[SW-1] ? (~sl_reg + 1'b1) : sl_reg;
        magr = sr_reg[SW-1] ? (~sr_reg + 1'b1) : sr_reg;
        nl   = 24'((64'(magl) << SH_L) >> SH_R);
        nr   = 24'((64'(magr) << SH_L) >> SH_R);
    end

    // Coefficients above full scale act as full scale.
    always_comb
    begin
        rc    = (cfg.rms_coef > FULL_Q24) ? FULL_Q24 : cfg.rms_coef;
        ac    = (cfg.attack_coef > FULL_Q24) ? FULL_Q24 : cfg.attack_coef;
        rc_lo = rc[11:0];
        rc_hi = rc[24:12];
    end

    // Knee region decision.
    always_comb
    begin
        two_over  = {over_reg, 1'b0};
        w_full    = signed'(28'({cfg.knee_width, 8'b0}));
        half_w    = signed'(28'({cfg.knee_width, 7'b0}));
        x_knee    = 28'(over_reg) + half_w;
        zone_low  = (two_over <= -w_full);
        zone_high = (two_over >= w_full);
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_SQL:
            begin
                op_a = 34'(nl);
                op_b = 34'(nl);
            end
            ST_SQR:
            begin
                op_a = 34'(nr);
                op_b = 34'(nr);
            end
            ST_M0:
            begin
                op_a = 34'(a_reg[23:0]);
                op_b = 34'(rc_lo);
            end
            ST_M1:
            begin
                op_a = 34'(a_reg[47:24]);
                op_b = 34'(rc_lo);
            end
            ST_M2:
            begin
                op_a = 34'(a_reg[23:0]);
                op_b = 34'(rc_hi);
            end
            ST_M3:
            begin
                op_a = 34'(a_reg[47:24]);
                op_b = 34'(rc_hi);
            end
            ST_IDX0:
            begin
                op_a = 34'(nrm_reg[23:0]);
                op_b = 34'(TABLE_DEPTH);
            end
            ST_IDX1:
            begin
                op_a = 34'(nrm_reg[47:24]);
                op_b = 34'(TABLE_DEPTH);
            end
            ST_LVL:
            begin
                op_a = 34'(lg_reg);
                op_b = 34'(DB_PER_OCT);
            end
            ST_TGT:
            begin
                if (zone_high) begin
                    op_a = 34'(over_reg);
                    op_b = 34'(cfg.slope);
                end
                else begin
                    op_a = 34'(x_knee);
                    op_b = 34'(x_knee);
                end
            end
            ST_KNEE:
            begin
                op_a = 34'(kt_reg);
                op_b = 34'(cfg.knee_curve);
            end
            ST_ENV:
            begin
                op_a = 34'(tgt_reg - red_reg);
                op_b = 34'(ac);
            end
            ST_EXP:
            begin
                op_a = 34'(red_reg);
                op_b = 34'(OCT_PER_DB);
            end
            ST_EIDX:
            begin
                op_a = 34'(e_reg[15:0]);
                op_b = 34'(TABLE_DEPTH);
            end
            ST_OL0:
            begin
                op_a = 34'(magl);
                op_b = 34'(g24_reg);
            end
            ST_OR0:
            begin
                op_a = 34'(magr);
                op_b = 34'(g24_reg);
            end
            ST_OL1, ST_OR1:
            begin
                op_a = 34'(t_reg);
                op_b = 34'(cfg.makeup_gain);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Output magnitude with the sample sign, saturated to the sample width.
    always_comb
    begin
        mag36 = prod[47:12];
        neg_s = (state_reg == ST_OL1) ? sl_reg[SW-1] : sr_reg[SW-1];
        if (neg_s) begin
            sat_val = (mag36 >= HALF36) ? SAT_MIN : SW'(~mag36 + 36'd1);
        end
        else begin
            sat_val = (mag36 >= HALF36) ? SAT_MAX : SW'(mag36);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        ovalid_next = ovalid_reg;
        msq_next    = msq_reg;
        red_next    = red_reg;
        sl_next     = sl_reg;
        sr_next     = sr_reg;
        acc_next    = acc_reg;
        a_next      = a_reg;
        dir_next    = dir_reg;
        nrm_next    = nrm_reg;
        lz_next     = lz_reg;
        idx_next    = idx_reg;
        lg_next     = lg_reg;
        over_next   = over_reg;
        tgt_next    = tgt_reg;
        kt_next     = kt_reg;
        e_next      = e_reg;
        eidx_next   = eidx_reg;
        g24_next    = g24_reg;
        t_next      = t_reg;
        resl_next   = resl_reg;
        resr_next   = resr_reg;
        outl_next   = outl_reg;
        outr_next   = outr_reg;
        meter_next  = meter_reg;
        sum64       = '0;
        amt         = '0;
        shamt       = '0;

        if (ovalid_reg && out_ready) begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    sl_next    = in_left;
                    sr_next    = in_right;
                    state_next = ST_SQL;
                end
            end
            ST_SQL:
            begin
                acc_next   = prod[63:0];
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                // Mean of the two squares.
                sum64      = acc_reg + prod[63:0];
                acc_next   = sum64 >> 1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                if (acc_reg[47:0] >= msq_reg) begin
                    dir_next = 1'b1;
                    a_next   = acc_reg[47:0] - msq_reg;
                end
                else begin
                    dir_next = 1'b0;
                    a_next   = msq_reg - acc_reg[47:0];
                end
                state_next = ST_M0;
            end
            ST_M0:
            begin
                acc_next   = prod[63:0];
                state_next = ST_M1;
            end
            ST_M1:
            begin
                acc_next   = acc_reg + (prod[63:0] << 24);
                state_next = ST_M2;
            end
            ST_M2:
            begin
                acc_next   = (acc_reg >> 12) + prod[63:0];
                state_next = ST_M3;
            end
            ST_M3:
            begin
                // Close the one-pole average step.
                sum64      = (acc_reg + (prod[63:0] << 24)) >> 12;
                msq_next   = dir_reg ? (msq_reg + sum64[47:0]) : (msq_reg - sum64[47:0]);
                step_next  = '0;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                // Leading-zero search, halving the shift each pass.
                if (step_reg == 3'd0) begin
                    nrm_next  = 49'(msq_reg) + 49'(LOG_EPS);
                    lz_next   = '0;
                    step_next = 3'd1;
                end
                else begin
                    amt = 6'd32 >> (step_reg - 3'd1);
                    if ((nrm_reg >> (7'd49 - 7'(amt))) == 49'd0) begin
                        nrm_next = nrm_reg << amt;
                        lz_next  = lz_reg + amt;
                    end
                    if (step_reg == 3'd6) begin
                        state_next = ST_IDX0;
                    end
                    else begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            ST_IDX0:
            begin
                acc_next   = prod[63:0];
                state_next = ST_IDX1;
            end
            ST_IDX1:
            begin
                sum64      = acc_reg + (prod[63:0] << 24);
                idx_next   = IDX_W'(sum64 >> 48);
                state_next = ST_LOG;
            end
            ST_LOG:
            begin
                lg_next    = ((25'sd2 - signed'({19'b0, lz_reg})) <<< 16)
                           + signed'({9'b0, log_val});
                state_next = ST_LVL;
            end
            ST_LVL:
            begin
                over_next  = 27'(prod >>> 16)
                           - 27'(signed'({cfg.threshold_db, 8'b0}));
                state_next = ST_TGT;
            end
            ST_TGT:
            begin
                if (zone_low) begin
                    tgt_next   = '0;
                    state_next = ST_ENV;
                end
                else if (zone_high) begin
                    tgt_next   = 32'(prod >>> 16);
                    state_next = ST_ENV;
                end
                else begin
                    kt_next    = 26'(prod >>> 16);
                    state_next = ST_KNEE;
                end
            end
            ST_KNEE:
            begin
                tgt_next   = (prod[67:48] != 20'd0) ? 32'hFFFF_FFFF : prod[47:16];
                state_next = ST_ENV;
            end
            ST_ENV:
            begin
                // Exponential attack, linear release.
                if (tgt_reg > red_reg) begin
                    red_next = red_reg + 32'(prod >>> 24);
                end
                else if (red_reg >= 32'(cfg.release_step)
                         && (red_reg - 32'(cfg.release_step)) > tgt_reg) begin
                    red_next = red_reg - 32'(cfg.release_step);
                end
                else begin
                    red_next = tgt_reg;
                end
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                e_next     = 30'(prod >>> 24);
                state_next = ST_EIDX;
            end
            ST_EIDX:
            begin
                eidx_next  = IDX_W'(prod >>> 16);
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                shamt      = 16'(e_reg[29:16]) + 16'd6;
                g24_next   = (shamt >= 16'd31) ? 25'd0 : 25'(exp_val >> shamt[4:0]);
                state_next = ST_OL0;
            end
            ST_OL0:
            begin
                t_next     = 32'(prod >>> 24);
                state_next = ST_OL1;
            end
            ST_OL1:
            begin
                resl_next  = sat_val;
                state_next = ST_OR0;
            end
            ST_OR0:
            begin
                t_next     = 32'(prod >>> 24);
                state_next = ST_OR1;
            end
            ST_OR1:
            begin
                resr_next  = sat_val;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hand the word over once the output register is free.
                if (!ovalid_reg || out_ready) begin
                    outl_next   = resl_reg;
                    outr_next   = resr_reg;
                    meter_next  = (red_reg[31:8] > 24'(METER_MAX)) ? METER_MAX
                                                                  : red_reg[22:8];
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
            msq_reg    <= '0;
            red_reg    <= '0;
        end
        else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
            msq_reg    <= msq_next;
            red_reg    <= red_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sl_reg    <= sl_next;
        sr_reg    <= sr_next;
        acc_reg   <= acc_next;
        a_reg     <= a_next;
        dir_reg   <= dir_next;
        nrm_reg   <= nrm_next;
        lz_reg    <= lz_next;
        idx_reg   <= idx_next;
        lg_reg    <= lg_next;
        over_reg  <= over_next;
        tgt_reg   <= tgt_next;
        kt_reg    <= kt_next;
        e_reg     <= e_next;
        eidx_reg  <= eidx_next;
        g24_reg   <= g24_next;
        t_reg     <= t_next;
        resl_reg  <= resl_next;
        resr_reg  <= resr_next;
        outl_reg  <= outl_next;
        outr_reg  <= outr_next;
        meter_reg <= meter_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_left  = outl_reg;
    assign out_right = outr_reg;
    assign out_meter = meter_reg;

endmodule

### src/rms_feedforward_compressor.sv
`timescale 1ns / 1ps

// Stereo-linked RMS feed-forward compressor.
// Input stream (s_axis_*): one word per stereo sample pair, left in the low
// bits, right above it. Output stream (m_axis_*): left_out, right_out and the
// current gain reduction in dB (unsigned Q7.8) for metering.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while the block is idle.
// Each pair runs through one shared multiplier under a sequencer; a word
// leaves once its steps have run; a level in the knee adds the ST_KNEE step.
// The input is ready only in the idle state, so a new word is taken only
// after the previous pair has reached the output register.
// The result sits in an output register; a stalled receiver holds it there
// and the next pair is still accepted, but that pair waits in its last step
// until the register is free.
// Reset clears the mean-square average and the smoothed reduction and loads
// the default register values.
module rms_feedforward_compressor #(
    parameter int SAMPLE_WIDTH = rmsc_pkg::SAMPLE_WIDTH_DEF,
    parameter int TABLE_DEPTH  = rmsc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rmsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rmsc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // left_sample, right_sample
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // left_out, right_out, reduction_db
    output logic [((2*SAMPLE_WIDTH+22)/8)*8-1:0]  m_axis_tdata
);

    import rmsc_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int OUT_W = ((2*SAMPLE_WIDTH+22)/8)*8;

    cfg_t          cfg_reg, cfg_next;
    logic [SW-1:0] out_left, out_right;
    logic [14:0]   out_meter;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_THRESHOLD_DB: cfg_next.threshold_db = signed'(cfg_data[15:0]);
                REG_SLOPE:        cfg_next.slope        = cfg_data[15:0];
                REG_KNEE_WIDTH:   cfg_next.knee_width   = cfg_data[12:0];
                REG_KNEE_CURVE:   cfg_next.knee_curve   = cfg_data[23:0];
                REG_MAKEUP_GAIN:  cfg_next.makeup_gain  = cfg_data[15:0];
                REG_RMS_COEF:     cfg_next.rms_coef     = cfg_data[24:0];
                REG_ATTACK_COEF:  cfg_next.attack_coef  = cfg_data[24:0];
                REG_RELEASE_STEP: cfg_next.release_step = cfg_data[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.threshold_db <= THRESHOLD_RST;
            cfg_reg.slope        <= SLOPE_RST;
            cfg_reg.knee_width   <= KNEE_WIDTH_RST;
            cfg_reg.knee_curve   <= KNEE_CURVE_RST;
            cfg_reg.makeup_gain  <= MAKEUP_GAIN_RST;
            cfg_reg.rms_coef     <= RMS_COEF_RST;
            cfg_reg.attack_coef  <= ATTACK_COEF_RST;
            cfg_reg.release_step <= RELEASE_STEP_RST;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    rmsc_engine #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_left   (signed'(s_axis_tdata[SW-1:0])),
        .in_right  (signed'(s_axis_tdata[2*SW-1:SW])),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_left  (out_left),
        .out_right (out_right),
        .out_meter (out_meter)
    );

    // Output word packing, zero fill above the meter.
    assign m_axis_tdata = OUT_W'({out_meter, out_right, out_left});

endmodule

### src/rmsc_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the compressor.
module rmsc_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((2*SAMPLE_WIDTH+22)/8)*8-1:0]  m_axis_tdata
);

    localparam int MOFF = 2 * SAMPLE_WIDTH;

    // The sequencer is busy right after it takes a word.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted word");

    // A result never appears in the cycle after a word is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result appeared right after an input word");

    // The reduction meter stays within 96 dB.
    a_meter_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[MOFF +: 15] <= 15'd24576))
        else $error("reduction meter out of range");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word changed while stalled");

endmodule

bind rms_feedforward_compressor rmsc_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rmsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
